// ----- rtl/zstring_text_decoder_unit_macros.svh -----
// Assertion macros shared by the text decoder RTL.
`ifndef ZSTRING_TEXT_DECODER_UNIT_MACROS_SVH
`define ZSTRING_TEXT_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ZSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ZSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/zsd_pkg.sv -----
// Types and constants for the packed text decoder.
`timescale 1ns / 1ps
`default_nettype none

package zsd_pkg;

    typedef enum logic [2:0] {
        KIND_INDEX   = 3'd0,
        KIND_LITERAL = 3'd1,
        KIND_SPACE   = 3'd2,
        KIND_NEWLINE = 3'd3,
        KIND_ABBREV  = 3'd4
    } kind_t;

    localparam logic [1:0] ALPHA_A0 = 2'd0;
    localparam logic [1:0] ALPHA_A1 = 2'd1;
    localparam logic [1:0] ALPHA_A2 = 2'd2;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    localparam logic [4:0] CODE_SPACE     = 5'd0;
    localparam logic [4:0] CODE_ABBREV_LO = 5'd1;
    localparam logic [4:0] CODE_ABBREV_HI = 5'd3;
    localparam logic [4:0] CODE_SHIFT_LO  = 5'd4;
    localparam logic [4:0] CODE_SHIFT_HI  = 5'd5;
    localparam logic [4:0] CODE_ESCAPE    = 5'd6;
    localparam logic [4:0] CODE_NEWLINE   = 5'd7;
    localparam logic [4:0] SHIFT_BIAS     = 5'd3;

    localparam int unsigned CODES_PER_WORD = 3;
    localparam int unsigned END_BIT        = 15;

    // Per-context shift and escape state
    typedef struct packed {
        logic [1:0] temp_alpha;
        logic [1:0] lock_alpha;
        logic [1:0] esc_phase;
        logic [4:0] esc_high;
    } ctx_t;

    // Full state seen by one code step
    typedef struct packed {
        ctx_t       ctx;
        logic       pend;
        logic [1:0] bank;
    } step_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/zsd_code_step.sv -----
// Decode of one 5-bit text code against the current shift/escape state.
`timescale 1ns / 1ps
`default_nettype none

module zsd_code_step #(
    parameter int unsigned ALPHABET_SIZE = 26
) (
    input  var zsd_pkg::step_t   state_in,
    input  wire logic [4:0]      code,
    input  wire logic [15:0]     table_base,
    output zsd_pkg::step_t       state_out,
    output logic                 emit,
    output zsd_pkg::result_t     res
);

    logic [1:0]  t;
    logic [1:0]  want;
    logic [1:0]  nt;
    logic [15:0] idx;

    assign t    = state_in.ctx.temp_alpha;
    assign want = 2'(code - zsd_pkg::SHIFT_BIAS);
    assign nt   = (t != want) ? zsd_pkg::ALPHA_A0 : t;
    assign idx  = 16'(16'(t) * 16'(ALPHABET_SIZE)) + 16'(code) - 16'(zsd_pkg::CODE_ESCAPE);

    always_comb
    begin
        state_out = state_in;
        emit      = 1'b0;
        res.kind  = zsd_pkg::KIND_INDEX;
        res.value = 16'd0;
        if (state_in.pend)
        begin
            emit                 = 1'b1;
            res.kind             = zsd_pkg::KIND_ABBREV;
            res.value            = table_base + {8'd0, state_in.bank, 6'd0}
                                   + {10'd0, code, 1'b0};
            state_out.pend       = 1'b0;
            state_out.ctx.temp_alpha = state_in.ctx.lock_alpha;
        end
        else if (state_in.ctx.esc_phase != zsd_pkg::ESC_IDLE)
        begin
            if (state_in.ctx.esc_phase == zsd_pkg::ESC_HIGH)
            begin
                state_out.ctx.esc_high  = code;
                state_out.ctx.esc_phase = zsd_pkg::ESC_LOW;
            end
            else
            begin
                emit                     = 1'b1;
                res.kind                 = zsd_pkg::KIND_LITERAL;
                res.value                = {6'd0, state_in.ctx.esc_high, code};
                state_out.ctx.esc_phase  = zsd_pkg::ESC_IDLE;
                state_out.ctx.temp_alpha = state_in.ctx.lock_alpha;
            end
        end
        else if (code == zsd_pkg::CODE_SPACE)
        begin
            emit                     = 1'b1;
            res.kind                 = zsd_pkg::KIND_SPACE;
            state_out.ctx.temp_alpha = state_in.ctx.lock_alpha;
        end
        else if (code inside {[zsd_pkg::CODE_ABBREV_LO:zsd_pkg::CODE_ABBREV_HI]})
        begin
            state_out.bank = 2'(code - zsd_pkg::CODE_ABBREV_LO);
            state_out.pend = 1'b1;
        end
        else if (code inside {[zsd_pkg::CODE_SHIFT_LO:zsd_pkg::CODE_SHIFT_HI]})
        begin
            if (t == zsd_pkg::ALPHA_A1 || t == zsd_pkg::ALPHA_A2)
            begin
                // shift from a non-default alphabet locks (or unlocks back to A0)
                state_out.ctx.temp_alpha = nt;
                state_out.ctx.lock_alpha = nt;
            end
            else
            begin
                state_out.ctx.temp_alpha = want;
            end
        end
        else if (t == zsd_pkg::ALPHA_A2 && code == zsd_pkg::CODE_ESCAPE)
        begin
            state_out.ctx.esc_phase = zsd_pkg::ESC_HIGH;
        end
        else if (t == zsd_pkg::ALPHA_A2 && code == zsd_pkg::CODE_NEWLINE)
        begin
            emit                     = 1'b1;
            res.kind                 = zsd_pkg::KIND_NEWLINE;
            state_out.ctx.temp_alpha = state_in.ctx.lock_alpha;
        end
        else
        begin
            emit                     = 1'b1;
            res.kind                 = zsd_pkg::KIND_INDEX;
            res.value                = idx;
            state_out.ctx.temp_alpha = state_in.ctx.lock_alpha;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/zsd_result_buf.sv -----
// Result buffer: packs up to three results of one word and drains them one per cycle while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none
`include "zstring_text_decoder_unit_macros.svh"

module zsd_result_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic [2:0]        emit,
    input  var zsd_pkg::result_t   res [3],
    output logic                   can_load,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             kind,
    output logic [15:0]            value,
    output logic                   last
);

    zsd_pkg::result_t ent_reg  [3];
    zsd_pkg::result_t ent_next [3];
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    zsd_pkg::result_t packed_res [3];
    logic [1:0]       n_emit;
    logic             fire;

    assign fire      = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign kind      = 3'(ent_reg[0].kind);
    assign value     = ent_reg[0].value;
    assign last      = (cnt_reg == 2'd1);
    assign n_emit    = 2'(emit[0]) + 2'(emit[1]) + 2'(emit[2]);

    // squeeze out the codes that produced nothing, keeping order
    always_comb
    begin
        packed_res[2] = res[2];
        if (emit[0])
        begin
            packed_res[0] = res[0];
            packed_res[1] = emit[1] ? res[1] : res[2];
        end
        else
        begin
            packed_res[0] = emit[1] ? res[1] : res[2];
            packed_res[1] = res[2];
        end
    end

    always_comb
    begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            ent_next = packed_res;
            cnt_next = n_emit;
        end
        else if (fire)
        begin
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    `ZSD_ASSERT_IMPL(a_load_when_free, clk, rst_n, load,
        (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready), "result buffer overwritten")
    `ZSD_ASSERT_NEXT(a_drain_count, clk, rst_n, fire && !load,
        cnt_reg == $past(cnt_reg) - 2'd1, "result count not decremented on transaction")

endmodule

`default_nettype wire

// ----- rtl/zstring_text_decoder_unit.sv -----
// Top level of the packed text decoder: input register, code chain, state, result buffer.
`timescale 1ns / 1ps
`default_nettype none
`include "zstring_text_decoder_unit_macros.svh"

// Packed text decoder. Each input transaction is one 16-bit text word (three
// 5-bit codes, high first, bit 15 = end of string) plus a nested flag that picks
// the abbreviation-string shift context. The word waits in the input register
// until the result buffer can take its results, then all three codes are decoded
// in one pass and their 0 to 3 results move into the result buffer, which hands
// out one result per cycle while out_ready is high, with last set on the word's
// final result. The next word's results are loaded in the same cycle that the
// previous word's last result is taken, and the input register takes a new word
// in the cycle its held word moves on. Write abbrev table base only while idle.
module zstring_text_decoder_unit #(
    parameter int unsigned ALPHABET_SIZE = 26
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] text_word,
    input  wire logic        nested,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic [15:0]      value,
    output logic             last
);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [15:0]      word_reg;
    logic             nested_reg;
    logic [15:0]      base_reg;
    zsd_pkg::ctx_t    ctx_reg [2];
    logic             pend_reg;
    logic [1:0]       bank_reg;

    zsd_pkg::step_t   chain [zsd_pkg::CODES_PER_WORD + 1];
    zsd_pkg::result_t res [3];
    logic [2:0]       emit;
    zsd_pkg::ctx_t    ctx_next;
    logic             pend_next;
    logic             can_load;
    logic             commit;
    logic             in_fire;

    assign commit   = in_valid_reg && can_load;
    assign in_ready = !in_valid_reg || commit;
    assign in_fire  = in_valid && in_ready;

    assign in_valid_next = in_fire ? 1'b1 : (commit ? 1'b0 : in_valid_reg);

    assign chain[0].ctx  = ctx_reg[nested_reg];
    assign chain[0].pend = pend_reg;
    assign chain[0].bank = bank_reg;

    for (genvar i = 0; i < zsd_pkg::CODES_PER_WORD; i++)
    begin : g_code
        zsd_code_step #(
            .ALPHABET_SIZE(ALPHABET_SIZE)
        ) u_step (
            .state_in  (chain[i]),
            .code      (word_reg[10 - 5 * i +: 5]),
            .table_base(base_reg),
            .state_out (chain[i + 1]),
            .emit      (emit[i]),
            .res       (res[i])
        );
    end

    // end of string wipes this context and any pending abbreviation
    assign ctx_next  = word_reg[zsd_pkg::END_BIT] ? '0 : chain[zsd_pkg::CODES_PER_WORD].ctx;
    assign pend_next = word_reg[zsd_pkg::END_BIT] ? 1'b0 : chain[zsd_pkg::CODES_PER_WORD].pend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            base_reg     <= 16'd0;
            ctx_reg[0]   <= '0;
            ctx_reg[1]   <= '0;
            pend_reg     <= 1'b0;
            bank_reg     <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            if (commit)
            begin
                ctx_reg[nested_reg] <= ctx_next;
                pend_reg            <= pend_next;
                bank_reg            <= chain[zsd_pkg::CODES_PER_WORD].bank;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            word_reg   <= text_word;
            nested_reg <= nested;
        end
    end

    zsd_result_buf u_result_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (commit),
        .emit     (emit),
        .res      (res),
        .can_load (can_load),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind     (kind),
        .value    (value),
        .last     (last)
    );

    `ZSD_ASSERT_NEXT(a_in_captured, clk, rst_n, in_fire, in_valid_reg,
        "accepted word not held in input register")
    `ZSD_ASSERT_NEXT(a_end_clears_pend, clk, rst_n, commit && word_reg[zsd_pkg::END_BIT],
        !pend_reg, "abbreviation still pending after end of string")

endmodule

`default_nettype wire

// ----- test/zstring_text_decoder_unit_tb.sv -----
// Self-checking testbench for the packed text decoder: directed words, random strings, stalls.
`timescale 1ns / 1ps

module zstring_text_decoder_unit_tb;
    import zsd_pkg::*;

    localparam int unsigned ALPHABET_SIZE   = 26;
    localparam logic [4:0]  FIRST_CHAR_CODE = 5'd6;
    localparam int          IDLE_PCT        = 36;
    localparam int          HOLD_CYCLES     = 150;
    localparam int          SETTLE_CYCLES   = 6;
    localparam int          STALL_LIMIT     = 2000;

    typedef struct {
        logic [15:0] word;
        logic        nested;
    } text_item_t;

    typedef struct {
        kind_t       kind;
        logic [15:0] value;
        logic        last;
    } symbol_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] text_word = '0;
    logic        nested = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [15:0] value;
    logic        last;

    zstring_text_decoder_unit #(.ALPHABET_SIZE(ALPHABET_SIZE)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_word  (text_word),
        .nested     (nested),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .value      (value),
        .last       (last)
    );

    // Decoder state as predicted
    logic [15:0] table_base = '0;
    logic [1:0]  temp_alpha [2] = '{ALPHA_A0, ALPHA_A0};
    logic [1:0]  lock_alpha [2] = '{ALPHA_A0, ALPHA_A0};
    logic [1:0]  esc_phase  [2] = '{ESC_IDLE, ESC_IDLE};
    logic [4:0]  esc_high   [2] = '{5'd0, 5'd0};
    logic        abbrev_pend = 1'b0;
    logic [1:0]  abbrev_bank = 2'd0;

    text_item_t  word_q [$];
    symbol_t     expected_symbols [$];
    text_item_t  drive_item;
    symbol_t     sym;

    int          words_queued = 0;
    int          words_taken = 0;
    int          nested_taken = 0;
    int          results_seen = 0;
    int          kind_seen [5] = '{0, 0, 0, 0, 0};
    int          cfg_writes = 0;
    int          mismatches = 0;
    int          stall_cnt = 0;
    int          hold_cnt = 0;
    logic        in_took = 1'b0;
    logic        steady = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_seen = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic push_symbol(input kind_t k, input logic [15:0] v);
        expected_symbols.push_back('{k, v, 1'b0});
    endtask

    // Decode one text word into the expected result stream
    task automatic decode_text_word(input logic [15:0] w, input logic ctx);
        logic [4:0] code;
        logic [1:0] t;
        logic [1:0] want;
        int         first;
        first = expected_symbols.size();
        for (int i = 0; i < CODES_PER_WORD; i++) begin
            code = 5'(w >> (10 - 5 * i));
            t = temp_alpha[ctx];
            if (abbrev_pend) begin
                push_symbol(KIND_ABBREV, 16'(table_base + {abbrev_bank, 6'd0} + {code, 1'b0}));
                abbrev_pend = 1'b0;
                temp_alpha[ctx] = lock_alpha[ctx];
            end else if (esc_phase[ctx] != ESC_IDLE) begin
                if (esc_phase[ctx] == ESC_HIGH) begin
                    esc_high[ctx] = code;
                    esc_phase[ctx] = ESC_LOW;
                end else begin
                    push_symbol(KIND_LITERAL, {6'd0, esc_high[ctx], code});
                    esc_phase[ctx] = ESC_IDLE;
                    temp_alpha[ctx] = lock_alpha[ctx];
                end
            end else if (code == CODE_SPACE) begin
                push_symbol(KIND_SPACE, 16'd0);
                temp_alpha[ctx] = lock_alpha[ctx];
            end else if (code <= CODE_ABBREV_HI) begin
                abbrev_bank = 2'(code - CODE_ABBREV_LO);
                abbrev_pend = 1'b1;
            end else if (code <= CODE_SHIFT_HI) begin
                want = 2'(code - SHIFT_BIAS);
                if (t == ALPHA_A1 || t == ALPHA_A2) begin
                    // second shift either locks or falls back to lowercase
                    if (t != want)
                        t = ALPHA_A0;
                    temp_alpha[ctx] = t;
                    lock_alpha[ctx] = t;
                end else begin
                    temp_alpha[ctx] = want;
                end
            end else if (t == ALPHA_A2 && code == CODE_ESCAPE) begin
                esc_phase[ctx] = ESC_HIGH;
            end else if (t == ALPHA_A2 && code == CODE_NEWLINE) begin
                push_symbol(KIND_NEWLINE, 16'd0);
                temp_alpha[ctx] = lock_alpha[ctx];
            end else begin
                push_symbol(KIND_INDEX, 16'(t * ALPHABET_SIZE + code - FIRST_CHAR_CODE));
                temp_alpha[ctx] = lock_alpha[ctx];
            end
        end
        if (w[END_BIT]) begin
            temp_alpha[ctx] = ALPHA_A0;
            lock_alpha[ctx] = ALPHA_A0;
            esc_phase[ctx] = ESC_IDLE;
            esc_high[ctx] = 5'd0;
            abbrev_pend = 1'b0;
        end
        if (expected_symbols.size() > first)
            expected_symbols[$].last = 1'b1;
    endtask

    // Input driver
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_took)) begin
            if (word_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                drive_item = word_q.pop_front();
                text_word <= drive_item.word;
                nested <= drive_item.nested;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output ready, with one long counted hold-off on request
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge clk) begin
        if (rst_n) begin
            in_took <= in_valid && in_ready;
            if (out_valid && out_ready) begin
                if (expected_symbols.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d value %h last %b",
                                              kind, value, last));
                end else begin
                    sym = expected_symbols.pop_front();
                    if (kind !== sym.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", kind, sym.kind));
                    if (value !== sym.value)
                        report_mismatch($sformatf("value %h, want %h (kind %0d)",
                                                  value, sym.value, sym.kind));
                    if (last !== sym.last)
                        report_mismatch($sformatf("last %b, want %b", last, sym.last));
                    results_seen++;
                    kind_seen[sym.kind]++;
                end
            end
            if (in_valid && in_ready) begin
                decode_text_word(text_word, nested);
                words_taken++;
                if (nested)
                    nested_taken++;
            end
            if (cfg_wr_en)
                table_base = cfg_wr_data;
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cnt <= 0;
            end else if (stall_cnt + 1 >= STALL_LIMIT) begin
                $display("%0t watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("zstring_text_decoder_unit_tb: errors");
                $finish;
            end else begin
                stall_cnt <= stall_cnt + 1;
            end
        end
    end

    function automatic logic [15:0] pack_word(input logic eos, input logic [4:0] a, b, c);
        return {eos, a, b, c};
    endfunction

    // Code mix weighted toward shifts and printable characters
    function automatic logic [4:0] rand_code();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 5'($urandom_range(31, 6));
        else if (r < 60)
            return 5'($urandom_range(5, 4));
        else if (r < 70)
            return CODE_SPACE;
        else if (r < 78)
            return 5'($urandom_range(3, 1));
        else
            return 5'($urandom_range(31, 0));
    endfunction

    task automatic queue_word(input logic [15:0] w, input logic n);
        word_q.push_back('{w, n});
        words_queued++;
    endtask

    task automatic queue_random_words(input int n);
        int   r;
        logic ctx;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            ctx = ($urandom_range(3) == 0);
            if (r < 10) begin
                queue_word(16'($urandom()), 1'($urandom()));
            end else if (r < 25) begin
                // escape opener, then a word carrying the literal
                queue_word(pack_word(1'b0, CODE_SHIFT_HI, CODE_ESCAPE, rand_code()), ctx);
                queue_word(pack_word($urandom_range(5) == 0, rand_code(), rand_code(),
                                     rand_code()), ctx);
            end else begin
                queue_word(pack_word($urandom_range(5) == 0, rand_code(), rand_code(),
                                     rand_code()), ctx);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (words_taken != words_queued || expected_symbols.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_table_base(input logic [15:0] base);
        wait_drained();
        // a word with no results may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_data <= base;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words, table base at its reset value
        queue_word(pack_word(1'b0, CODE_SPACE, 5'd6, 5'd31), 1'b0);
        queue_word(pack_word(1'b0, CODE_SHIFT_LO, 5'd6, CODE_SHIFT_HI), 1'b0);
        queue_word(pack_word(1'b0, CODE_NEWLINE, 5'd6, CODE_SPACE), 1'b0);
        queue_word(pack_word(1'b0, CODE_SHIFT_LO, CODE_SHIFT_LO, 5'd6), 1'b0);
        queue_word(pack_word(1'b0, CODE_SHIFT_HI, CODE_SHIFT_HI, 5'd10), 1'b0);
        queue_word(pack_word(1'b0, CODE_SHIFT_HI, CODE_ESCAPE, 5'd20), 1'b0);
        queue_word(pack_word(1'b0, 5'd17, CODE_SPACE, CODE_SPACE), 1'b0);
        queue_word(pack_word(1'b0, 5'd1, 5'd12, 5'd2), 1'b0);
        queue_word(pack_word(1'b0, 5'd31, 5'd3, 5'd9), 1'b0);
        // escape split across contexts
        queue_word(pack_word(1'b0, CODE_SHIFT_HI, CODE_ESCAPE, CODE_SPACE), 1'b1);
        queue_word(pack_word(1'b0, 5'd8, CODE_SPACE, CODE_SPACE), 1'b0);
        queue_word(pack_word(1'b0, 5'd3, 5'd4, 5'd9), 1'b1);
        // string ends mid-escape, then mid-abbreviation
        queue_word(pack_word(1'b1, CODE_SHIFT_HI, CODE_ESCAPE, CODE_NEWLINE), 1'b0);
        queue_word(pack_word(1'b0, 5'd6, 5'd6, 5'd6), 1'b0);
        queue_word(pack_word(1'b1, CODE_SPACE, CODE_SPACE, 5'd1), 1'b0);
        queue_word(pack_word(1'b0, 5'd6, 5'd7, 5'd8), 1'b0);
        // abbreviation inside a nested string
        queue_word(pack_word(1'b1, 5'd2, CODE_SHIFT_HI, CODE_SPACE), 1'b1);
        queue_word(16'h0000, 1'b0);
        queue_word(16'hFFFF, 1'b1);
        queue_word(16'h7FFF, 1'b0);
        // word with no output, then chained abbreviations
        queue_word(pack_word(1'b0, CODE_SHIFT_LO, CODE_SHIFT_HI, 5'd1), 1'b0);
        queue_word(pack_word(1'b1, 5'd1, 5'd1, 5'd1), 1'b0);
        // locked punctuation alphabet with escape and newline
        queue_word(pack_word(1'b0, CODE_SHIFT_HI, CODE_SHIFT_HI, CODE_ESCAPE), 1'b0);
        queue_word(pack_word(1'b0, 5'd1, 5'd2, CODE_NEWLINE), 1'b0);
        queue_word(pack_word(1'b1, CODE_ESCAPE, 5'd0, 5'd0), 1'b0);

        write_table_base(16'hFFFF);
        queue_random_words(100);

        write_table_base(16'($urandom()));
        steady <= 1'b1;
        queue_random_words(80);
        wait_drained();
        steady <= 1'b0;

        // receiver stalls while words keep coming
        write_table_base(16'h0000);
        hold_req <= 1'b1;
        queue_random_words(60);

        write_table_base(16'($urandom()));
        queue_random_words(60);

        wait_drained();
        repeat (10) @(negedge clk);

        $display("covered %0d words (%0d nested), %0d results: %0d chars, %0d literals,",
                 words_taken, nested_taken, results_seen, kind_seen[KIND_INDEX],
                 kind_seen[KIND_LITERAL]);
        $display("  %0d spaces, %0d newlines, %0d abbreviations; %0d table base writes",
                 kind_seen[KIND_SPACE], kind_seen[KIND_NEWLINE], kind_seen[KIND_ABBREV],
                 cfg_writes);
        if (mismatches == 0 && expected_symbols.size() == 0) begin
            $display("zstring_text_decoder_unit_tb: clean");
        end else begin
            $display("zstring_text_decoder_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ----- zstring_text_decoder_unit.f -----
+incdir+rtl
rtl/zsd_pkg.sv
rtl/zsd_code_step.sv
rtl/zsd_result_buf.sv
rtl/zstring_text_decoder_unit.sv
test/zstring_text_decoder_unit_tb.sv
